>>> rtl/slipdf_pkg.sv
// Package for the SLIP receive deframer with checksum.
// Holds the framing symbols, status codes, size constants and the result type.
// No dependencies.
`default_nettype none

package slipdf_pkg;

    localparam int MAX_FRAME_BYTES = 128;

    localparam int COUNT_W  = 8;
    localparam int PCOUNT_W = 7;
    localparam int STATUS_W = 3;

    localparam logic [7:0] SYM_END     = 8'hC0;
    localparam logic [7:0] SYM_ESC     = 8'hDB;
    localparam logic [7:0] SYM_ESC_END = 8'hDC;
    localparam logic [7:0] SYM_ESC_ESC = 8'hDD;
    localparam logic [7:0] SUM_INVERT  = 8'hFF;

    localparam logic [STATUS_W-1:0] ST_GOOD      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_START = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISMATCH  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;

    localparam logic [COUNT_W:0] MAX_BYTES_EXT = (COUNT_W+1)'(MAX_FRAME_BYTES);
    localparam logic [PCOUNT_W-1:0] OVF_COUNT  = PCOUNT_W'(MAX_FRAME_BYTES - 2);

    typedef struct packed {
        logic                is_frame_end;
        logic [7:0]          payload_byte;
        logic [STATUS_W-1:0] frame_status;
        logic [PCOUNT_W-1:0] payload_count;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/slipdf_step.sv
// Per-byte deframing step: frame state registers and the unescape/checksum logic.
// Depends on slipdf_pkg.
`default_nettype none

module slipdf_step
    import slipdf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_step,
    input  wire logic [7:0] i_byte,
    output logic         o_res_valid,
    output t_result      o_res
);

    logic               r_esc;
    logic [COUNT_W-1:0] r_cnt;
    logic [7:0]         r_first;
    logic [7:0]         r_held;
    logic [7:0]         r_sum;

    logic               n_esc;
    logic [COUNT_W-1:0] n_cnt;
    logic [7:0]         n_first;
    logic [7:0]         n_held;
    logic [7:0]         n_sum;

    logic [7:0]         data;
    logic [COUNT_W:0]   next_idx;
    logic [COUNT_W-1:0] cnt_m2;

    assign next_idx = {1'b0, r_cnt} + (COUNT_W+1)'(1);
    assign cnt_m2   = r_cnt - COUNT_W'(2);

    always_comb begin
        data = i_byte;
        if (r_esc) begin
            if (i_byte == SYM_ESC_END) begin
                data = SYM_END;
            end else if (i_byte == SYM_ESC_ESC) begin
                data = SYM_ESC;
            end
        end
    end

    always_comb begin
        n_esc   = r_esc;
        n_cnt   = r_cnt;
        n_first = r_first;
        n_held  = r_held;
        n_sum   = r_sum;
        o_res_valid = 1'b0;
        o_res   = '0;

        if (i_byte == SYM_END && r_cnt != '0) begin
            // Frame close: report, clear the frame, keep any pending escape.
            o_res_valid = 1'b1;
            o_res.is_frame_end = 1'b1;
            o_res.payload_count = (r_cnt >= COUNT_W'(2)) ? cnt_m2[PCOUNT_W-1:0] : '0;
            priority if (r_first != SYM_END) begin
                o_res.frame_status = ST_BAD_START;
            end else if (r_cnt < COUNT_W'(2)) begin
                o_res.frame_status = ST_SHORT;
            end else if ((r_sum ^ SUM_INVERT) == r_held) begin
                o_res.frame_status = ST_GOOD;
            end else begin
                o_res.frame_status = ST_MISMATCH;
            end
            n_cnt   = '0;
            n_first = '0;
            n_held  = '0;
            n_sum   = '0;
        end else if (i_byte == SYM_ESC) begin
            n_esc = 1'b1;
        end else begin
            n_esc = 1'b0;
            if (r_cnt == '0) begin
                n_first = data;
            end else if (r_cnt == COUNT_W'(1)) begin
                n_held = data;
            end else begin
                // The held byte is now known not to be the checksum.
                o_res_valid = 1'b1;
                o_res.payload_byte = r_held;
                n_sum  = r_sum + r_held;
                n_held = data;
            end
            if (next_idx >= MAX_BYTES_EXT) begin
                // Overflow report replaces any payload byte of this step.
                o_res_valid = 1'b1;
                o_res = '0;
                o_res.is_frame_end  = 1'b1;
                o_res.frame_status  = ST_OVERFLOW;
                o_res.payload_count = OVF_COUNT;
                n_cnt   = '0;
                n_first = '0;
                n_held  = '0;
                n_sum   = '0;
            end else begin
                n_cnt = next_idx[COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc   <= 1'b0;
            r_cnt   <= '0;
            r_first <= '0;
            r_held  <= '0;
            r_sum   <= '0;
        end else if (i_step) begin
            r_esc   <= n_esc;
            r_cnt   <= n_cnt;
            r_first <= n_first;
            r_held  <= n_held;
            r_sum   <= n_sum;
        end
    end

endmodule

`default_nettype wire

>>> rtl/slipdf_out_reg.sv
// Output result register with valid/stall handshake.
// Depends on slipdf_pkg.
`default_nettype none

module slipdf_out_reg
    import slipdf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load_en,
    input  wire logic    i_load_valid,
    input  wire t_result i_res,
    input  wire logic    i_stall,
    output logic         o_can_load,
    output logic         o_valid,
    output t_result      o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_can_load = !r_valid || !i_stall;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load_en && i_load_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load_en && i_load_valid) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

>>> rtl/slip_rx_deframer_with_checksum_core.sv
// Top level of the SLIP receive deframer with inverted additive checksum.
// Depends on slipdf_pkg, slipdf_step and slipdf_out_reg.
`default_nettype none

// The block takes one raw line byte per transfer on the input channel and
// undoes SLIP escaping (0xDB escape, 0xDC -> 0xC0, 0xDD -> 0xDB). A 0xC0 on a
// non-empty frame closes it; on an empty frame it is stored as the start
// byte. Payload bytes come out one byte late so that the last byte of each
// frame can be checked as the inverted 8-bit sum of the payload. A closed
// frame yields one report transfer with is_frame_end high and a status of
// good, bad start byte, too short or checksum mismatch; a frame reaching the
// maximum length yields an overflow report and is dropped. Bytes that only
// start a frame or mark an escape produce no output transfer. Each byte
// passes through an input register, decode logic against the frame state and
// an output register, so the block sustains one byte per clock while the
// output is not stalled; the output register stalling is the only thing
// that holds the input back.

module slip_rx_deframer_with_checksum_core
    import slipdf_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [7:0]          i_rx_byte,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic                     o_is_frame_end,
    output logic [7:0]               o_payload_byte,
    output logic [STATUS_W-1:0]      o_frame_status,
    output logic [PCOUNT_W-1:0]      o_payload_count
);

    // Input register stage.
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    logic    out_can_load;
    logic    advance;
    logic    step_res_valid;
    t_result step_res;
    t_result out_res;

    // The registered byte is processed in the cycle it moves to the output.
    assign advance = r_in_valid && out_can_load;
    // Stall only when a held byte cannot move on this cycle.
    assign o_stall = r_in_valid && !out_can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    slipdf_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_byte      (r_in_byte),
        .o_res_valid (step_res_valid),
        .o_res       (step_res)
    );

    slipdf_out_reg u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_en    (r_in_valid),
        .i_load_valid (step_res_valid),
        .i_res        (step_res),
        .i_stall      (i_stall),
        .o_can_load   (out_can_load),
        .o_valid      (o_valid),
        .o_res        (out_res)
    );

    assign o_is_frame_end  = out_res.is_frame_end;
    assign o_payload_byte  = out_res.payload_byte;
    assign o_frame_status  = out_res.frame_status;
    assign o_payload_count = out_res.payload_count;

endmodule

`default_nettype wire
